[rtl/core/space_saving_heavy_hitter_table_unit_assert.svh]
// assertion helpers for the heavy-hitter table
`ifndef SPACE_SAVING_HEAVY_HITTER_TABLE_UNIT_ASSERT_SVH
`define SPACE_SAVING_HEAVY_HITTER_TABLE_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define SSHH_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sshh assertion failed");

// next-cycle implication, sampled on clk_i, off during reset
`define SSHH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sshh assertion failed");

`endif

[rtl/core/sshh_pkg.sv]
`default_nettype none

package sshh_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned IdxW     = $clog2(Capacity);
  localparam int unsigned UsedW    = $clog2(Capacity + 1);
  localparam int unsigned KeyW     = 32;
  localparam int unsigned CountW   = 32;
  localparam int unsigned StampW   = 40;
  localparam int unsigned CapW     = 7;
  localparam int unsigned CapReset = 64;
  localparam int unsigned CmpW     = (UsedW > CapW) ? UsedW : CapW;

  localparam logic [CountW-1:0] CountMax = '1;

  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [CountW-1:0] count;
    logic [CountW-1:0] over_est;
    logic [StampW-1:0] stamp;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic scan_rd;
    logic commit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic rd_pend;
    logic out_free;
  } dp_status_t;

  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StScan   = 3'b010,
    StCommit = 3'b100
  } ctrl_state_e;

endpackage

`default_nettype wire

[rtl/core/sshh_if.sv]
`default_nettype none

interface sshh_key_if import sshh_pkg::*;;
  logic            valid;
  logic            ready;
  logic [KeyW-1:0] key;

  modport source (output valid, output key, input ready);
  modport sink   (input valid, input key, output ready);
endinterface

interface sshh_result_if import sshh_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CountW-1:0] count;
  logic [CountW-1:0] over_estimate;
  logic              was_new;
  logic              evicted;
  logic [KeyW-1:0]   evicted_key;

  modport source (output valid, output count, output over_estimate, output was_new,
                  output evicted, output evicted_key, input ready);
  modport sink   (input valid, input count, input over_estimate, input was_new,
                  input evicted, input evicted_key, output ready);
endinterface

interface sshh_cfg_if import sshh_pkg::*;;
  logic            valid;
  logic            ready;
  logic [CapW-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/space_saving_heavy_hitter_table_unit.sv]
// Space-saving top-k table: every key item updates a table of up to 64 monitored
// keys and returns one result item with the key's new count, its over-estimate,
// whether it was newly inserted, and which key (if any) it displaced. The
// single-read-port entry memory is scanned one entry per cycle for the first key
// match and for the eviction candidate (smallest count, earliest stamp on ties),
// then the updated entry is written back once the result register is free; the
// next item can be taken in the cycle after that write-back. The result sits in
// an output register, so the next item is accepted while it waits. The capacity
// register may be written only while the block is idle.
`default_nettype none
`include "space_saving_heavy_hitter_table_unit_assert.svh"

module space_saving_heavy_hitter_table_unit import sshh_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  sshh_key_if.sink      key_chan_i,
  sshh_cfg_if.sink      cfg_chan_i,
  sshh_result_if.source result_chan_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;

  assign key_chan_i.ready = in_ready;

  // sequencer: idle, scan entries, commit write-back
  sshh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (key_chan_i.valid),
    .in_ready_o (in_ready),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  // entry memory, search registers, update logic and result register
  sshh_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .key_i         (key_chan_i.key),
    .cfg_chan_i    (cfg_chan_i),
    .result_chan_o (result_chan_o)
  );

  // write-back only when the result register can take the item
  `SSHH_ASSERT_NOW(a_commit_out_free, cmd.commit, status.out_free)
  // a committed item shows up at the output next cycle
  `SSHH_ASSERT_NEXT(a_commit_shows, cmd.commit, result_chan_o.valid)
  // busy once an item is taken
  `SSHH_ASSERT_NEXT(a_busy_after_accept, key_chan_i.valid && key_chan_i.ready, !key_chan_i.ready)
  // no read issued while committing
  `SSHH_ASSERT_NOW(a_no_read_on_commit, cmd.commit, !cmd.scan_rd && !status.rd_pend)

endmodule

`default_nettype wire

[rtl/core/sshh_ctrl.sv]
`default_nettype none

module sshh_ctrl import sshh_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output ctrl_cmd_t  cmd_o,
  input  dp_status_t status_i
);

  ctrl_state_e state_q, state_d;

  assign in_ready_o    = (state_q == StIdle);
  assign cmd_o.start   = in_valid_i && (state_q == StIdle);
  assign cmd_o.scan_rd = (state_q == StScan) && !status_i.scan_done;
  assign cmd_o.commit  = (state_q == StCommit) && status_i.out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StScan;
      end
      StScan: begin
        // last read compared once nothing is in flight
        if (status_i.scan_done && !status_i.rd_pend) state_d = StCommit;
      end
      StCommit: begin
        if (status_i.out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/sshh_datapath.sv]
`default_nettype none

module sshh_datapath import sshh_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_cmd_t        cmd_i,
  output dp_status_t       status_o,
  input  logic [KeyW-1:0]  key_i,
  sshh_cfg_if.sink         cfg_chan_i,
  sshh_result_if.source    result_chan_o
);

  // entry table
  entry_t mem_q [Capacity];

  logic [CapW-1:0]   cap_q;
  logic [UsedW-1:0]  used_q;
  logic [StampW-1:0] seq_q;
  logic [KeyW-1:0]   key_q;
  logic [StampW-1:0] stamp_q;
  logic [UsedW-1:0]  scan_idx_q;
  logic              rd_vld_q;
  logic [IdxW-1:0]   rd_idx_q;
  entry_t            rd_data_q;
  logic              found_q;
  logic [IdxW-1:0]   hit_idx_q;
  entry_t            hit_q;
  logic              vic_vld_q;
  logic [IdxW-1:0]   vic_idx_q;
  entry_t            vic_q;

  logic              out_vld_q;
  logic [CountW-1:0] out_count_q;
  logic [CountW-1:0] out_oe_q;
  logic              out_new_q;
  logic              out_ev_q;
  logic [KeyW-1:0]   out_evkey_q;

  logic              key_hit;
  logic              take_vic;
  logic [CmpW-1:0]   cap_ext;
  logic [CmpW-1:0]   cap_eff;
  logic              room;
  logic [IdxW-1:0]   wr_idx;
  entry_t            wr_data;
  logic              wr_new;
  logic              wr_ev;
  logic [KeyW-1:0]   wr_evkey;
  logic              bump_used;

  assign cfg_chan_i.ready = 1'b1;

  assign status_o.scan_done = (scan_idx_q == used_q);
  assign status_o.rd_pend   = rd_vld_q;
  assign status_o.out_free  = !out_vld_q || result_chan_o.ready;

  assign key_hit  = rd_vld_q && (rd_data_q.key == key_q);
  assign take_vic = rd_vld_q && (!vic_vld_q || (rd_data_q.count < vic_q.count) ||
                    ((rd_data_q.count == vic_q.count) && (rd_data_q.stamp < vic_q.stamp)));

  // zero acts as one, anything above the table size as the table size
  always_comb begin
    cap_ext = CmpW'(cap_q);
    if (cap_ext == '0) begin
      cap_eff = CmpW'(1);
    end else if (cap_ext > CmpW'(Capacity)) begin
      cap_eff = CmpW'(Capacity);
    end else begin
      cap_eff = cap_ext;
    end
  end
  assign room = CmpW'(used_q) < cap_eff;

  always_comb begin
    wr_idx    = vic_idx_q;
    wr_data   = vic_q;
    wr_new    = 1'b0;
    wr_ev     = 1'b0;
    wr_evkey  = '0;
    bump_used = 1'b0;
    if (found_q) begin
      wr_idx  = hit_idx_q;
      wr_data = hit_q;
      // saturated hit keeps count and stamp
      if (hit_q.count != CountMax) begin
        wr_data.count = hit_q.count + CountW'(1);
        wr_data.stamp = stamp_q;
      end
    end else if (room) begin
      wr_idx           = used_q[IdxW-1:0];
      wr_data.key      = key_q;
      wr_data.count    = CountW'(1);
      wr_data.over_est = '0;
      wr_data.stamp    = stamp_q;
      wr_new           = 1'b1;
      bump_used        = 1'b1;
    end else begin
      wr_data.key      = key_q;
      wr_data.over_est = vic_q.count;
      wr_data.count    = (vic_q.count != CountMax) ? vic_q.count + CountW'(1) : CountMax;
      wr_data.stamp    = stamp_q;
      wr_new           = 1'b1;
      wr_ev            = 1'b1;
      wr_evkey         = vic_q.key;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      mem_q[wr_idx] <= wr_data;
    end
    if (cmd_i.scan_rd) begin
      rd_data_q <= mem_q[scan_idx_q[IdxW-1:0]];
    end
  end

  // search payload
  always_ff @(posedge clk_i) begin
    rd_idx_q <= scan_idx_q[IdxW-1:0];
    if (cmd_i.start) begin
      key_q   <= key_i;
      stamp_q <= seq_q;
    end
    if (key_hit && !found_q) begin
      hit_idx_q <= rd_idx_q;
      hit_q     <= rd_data_q;
    end
    if (take_vic) begin
      vic_idx_q <= rd_idx_q;
      vic_q     <= rd_data_q;
    end
    if (cmd_i.commit) begin
      out_count_q <= wr_data.count;
      out_oe_q    <= wr_data.over_est;
      out_new_q   <= wr_new;
      out_ev_q    <= wr_ev;
      out_evkey_q <= wr_evkey;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q      <= CapW'(CapReset);
      used_q     <= '0;
      seq_q      <= '0;
      scan_idx_q <= '0;
      rd_vld_q   <= 1'b0;
      found_q    <= 1'b0;
      vic_vld_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_chan_i.valid) begin
        cap_q <= cfg_chan_i.data;
      end
      rd_vld_q <= cmd_i.scan_rd;
      if (cmd_i.start) begin
        seq_q      <= seq_q + StampW'(1);
        scan_idx_q <= '0;
        found_q    <= 1'b0;
        vic_vld_q  <= 1'b0;
      end else begin
        if (cmd_i.scan_rd) scan_idx_q <= scan_idx_q + UsedW'(1);
        if (key_hit)       found_q    <= 1'b1;
        if (take_vic)      vic_vld_q  <= 1'b1;
      end
      if (cmd_i.commit && bump_used) begin
        used_q <= used_q + UsedW'(1);
      end
      if (cmd_i.commit) begin
        out_vld_q <= 1'b1;
      end else if (result_chan_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign result_chan_o.valid         = out_vld_q;
  assign result_chan_o.count         = out_count_q;
  assign result_chan_o.over_estimate = out_oe_q;
  assign result_chan_o.was_new       = out_new_q;
  assign result_chan_o.evicted       = out_ev_q;
  assign result_chan_o.evicted_key   = out_evkey_q;

endmodule

`default_nettype wire

[test/heavy_hitter_tracker.sv]
`default_nettype none

module heavy_hitter_tracker import sshh_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  sshh_key_if    key_chan,
  sshh_cfg_if    cfg_chan,
  sshh_result_if result_chan,
  output int     mismatches_o,
  output int     outstanding_o,
  output int     checked_o,
  output int     evictions_o
);

  typedef struct packed {
    logic [CountW-1:0] count;
    logic [CountW-1:0] over_estimate;
    logic              was_new;
    logic              evicted;
    logic [KeyW-1:0]   evicted_key;
  } tally_t;

  // shadow of the monitored-key table
  logic              slot_valid [Capacity];
  logic [KeyW-1:0]   slot_key   [Capacity];
  logic [CountW-1:0] slot_count [Capacity];
  logic [CountW-1:0] slot_over  [Capacity];
  logic [StampW-1:0] slot_stamp [Capacity];
  int unsigned       slots_used;
  logic [StampW-1:0] arrival_seq;
  logic [CapW-1:0]   capacity_reg;

  tally_t pending_results[$];
  int     mismatches = 0;
  int     checked    = 0;
  int     evictions  = 0;

  function automatic int unsigned effective_limit(input logic [CapW-1:0] c);
    if (c == '0) return 1;
    if (c > Capacity) return Capacity;
    return c;
  endfunction

  // one table update for one key, returns the result item it should produce
  function automatic tally_t count_key(input logic [KeyW-1:0] k);
    tally_t            t;
    logic [StampW-1:0] now;
    logic [CountW-1:0] old;
    int                hit;
    int                victim;
    bit                found;
    bit                have_victim;
    t           = '0;
    now         = arrival_seq;
    arrival_seq = arrival_seq + 1'b1;
    hit         = 0;
    victim      = 0;
    found       = 1'b0;
    have_victim = 1'b0;
    for (int i = 0; i < Capacity; i++) begin
      if (slot_valid[i]) begin
        if (!found && slot_key[i] == k) begin
          found = 1'b1;
          hit   = i;
        end
        if (!have_victim || slot_count[i] < slot_count[victim] ||
            (slot_count[i] == slot_count[victim] && slot_stamp[i] < slot_stamp[victim])) begin
          victim      = i;
          have_victim = 1'b1;
        end
      end
    end
    if (found) begin
      if (slot_count[hit] != CountMax) begin
        slot_count[hit] = slot_count[hit] + 1'b1;
        slot_stamp[hit] = now;
      end
      t.count         = slot_count[hit];
      t.over_estimate = slot_over[hit];
    end else if (slots_used < effective_limit(capacity_reg) && slots_used < Capacity) begin
      slot_valid[slots_used] = 1'b1;
      slot_key[slots_used]   = k;
      slot_count[slots_used] = 1;
      slot_over[slots_used]  = '0;
      slot_stamp[slots_used] = now;
      slots_used             = slots_used + 1;
      t.count                = 1;
      t.was_new              = 1'b1;
    end else if (have_victim) begin
      old                = slot_count[victim];
      t.evicted_key      = slot_key[victim];
      slot_key[victim]   = k;
      slot_over[victim]  = old;
      slot_count[victim] = (old != CountMax) ? old + 1'b1 : CountMax;
      slot_stamp[victim] = now;
      t.count            = slot_count[victim];
      t.over_estimate    = old;
      t.was_new          = 1'b1;
      t.evicted          = 1'b1;
    end
    return t;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s: got %h, expected %h (result %0d)", what, got, want, checked);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    tally_t want;
    tally_t fresh;
    if (!rst_ni) begin
      for (int i = 0; i < Capacity; i++) slot_valid[i] = 1'b0;
      slots_used   = 0;
      arrival_seq  = '0;
      capacity_reg = CapW'(CapReset);
      pending_results.delete();
    end else begin
      // results leave before new keys enter
      if (result_chan.valid && result_chan.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no item waiting", result_chan.count, '0);
        end else begin
          want = pending_results.pop_front();
          if (result_chan.count !== want.count)
            report_mismatch("count", result_chan.count, want.count);
          if (result_chan.over_estimate !== want.over_estimate)
            report_mismatch("over_estimate", result_chan.over_estimate, want.over_estimate);
          if (result_chan.was_new !== want.was_new)
            report_mismatch("was_new", result_chan.was_new, want.was_new);
          if (result_chan.evicted !== want.evicted)
            report_mismatch("evicted", result_chan.evicted, want.evicted);
          if (result_chan.evicted_key !== want.evicted_key)
            report_mismatch("evicted_key", result_chan.evicted_key, want.evicted_key);
          checked++;
        end
      end
      if (cfg_chan.valid && cfg_chan.ready) capacity_reg = cfg_chan.data;
      if (key_chan.valid && key_chan.ready) begin
        fresh = count_key(key_chan.key);
        if (fresh.evicted) evictions++;
        pending_results.insert(pending_results.size(), fresh);
      end
    end
    mismatches_o  <= mismatches;
    outstanding_o <= pending_results.size();
    checked_o     <= checked;
    evictions_o   <= evictions;
  end

endmodule

`default_nettype wire

[test/testbench.sv]
`default_nettype none

module testbench;
  import sshh_pkg::*;

  // generous cycle budget: ~450 items plus long sender gaps, long receiver
  // stalls, two deliberate holds and drains
  localparam int Limit      = 600000;
  localparam int HoldCycles = 400;
  localparam int PhaseItems = 72;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #10 clk_i = ~clk_i;

  sshh_key_if    key_chan ();
  sshh_cfg_if    cfg_chan ();
  sshh_result_if result_chan ();

  space_saving_heavy_hitter_table_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .key_chan_i    (key_chan),
    .cfg_chan_i    (cfg_chan),
    .result_chan_o (result_chan)
  );

  int mismatches;
  int outstanding;
  int checked;
  int evictions;

  // watches all three channels, predicts every result and compares
  heavy_hitter_tracker tracker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .key_chan      (key_chan),
    .cfg_chan      (cfg_chan),
    .result_chan   (result_chan),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .checked_o     (checked),
    .evictions_o   (evictions)
  );

  // key pools: a few heavy hitters, a wider warm set, plus noise
  logic [KeyW-1:0] hot_keys  [8];
  logic [KeyW-1:0] warm_keys [48];
  bit              quiet;
  int              items_sent;
  int              cycles;

  // watchdog on total run length
  initial begin
    cycles = 0;
    while (cycles < Limit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results still due", cycles, outstanding);
    $display("space_saving_heavy_hitter_table_unit verification failed");
    $finish;
  end

  // mostly back-to-back, some short gaps, rare long ones; none in quiet stretches
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 90);
  endfunction

  // skewed key stream so that hits, inserts and evictions all show up
  function automatic logic [KeyW-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return hot_keys[$urandom_range(0, 7)];
    if (r < 80) return warm_keys[$urandom_range(0, 47)];
    if (r < 90) return KeyW'($urandom_range(0, 15));
    return $urandom;
  endfunction

  // offer one key, leave valid high after acceptance
  task automatic send_key(input logic [KeyW-1:0] k);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      key_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    key_chan.valid <= 1'b1;
    key_chan.key   <= k;
    do @(posedge clk_i); while (!key_chan.ready);
    items_sent++;
  endtask

  // stop offering and wait until every predicted result came back
  task automatic wait_drained();
    key_chan.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  // capacity write, only ever issued with the table idle
  task automatic write_capacity(input logic [CapW-1:0] cap);
    cfg_chan.valid <= 1'b1;
    cfg_chan.data  <= cap;
    do @(posedge clk_i); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
  endtask

  // result side: random stalls, plus two long holds while keys keep coming
  initial begin : result_sink
    int taken;
    int gap;
    bit held_early;
    bit held_late;
    taken      = 0;
    held_early = 1'b0;
    held_late  = 1'b0;
    result_chan.ready <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (taken >= 270 && !held_late) begin
        held_late = 1'b1;
        gap       = HoldCycles;
      end else if (taken >= 120 && !held_early) begin
        held_early = 1'b1;
        gap        = HoldCycles;
      end else begin
        gap = pick_gap();
      end
      if (gap > 0) begin
        result_chan.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      result_chan.ready <= 1'b1;
      @(posedge clk_i);
      if (result_chan.valid && result_chan.ready) taken++;
    end
  end

  initial begin : stimulus
    logic [CapW-1:0] phase_caps [6];
    logic [KeyW-1:0] opening    [16];
    // small table of 4: fill, hit, then evict through tied minimum counts
    opening = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001,
                32'h0000_0002, 32'h0000_0003, 32'h0000_0005, 32'h0000_0005,
                32'h0000_0001, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0000,
                32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h0000_0005};
    // growing capacity first, then back down below the fill level
    phase_caps = '{7'd1, 7'd8, 7'd127, 7'd64, 7'd30, 7'd2};
    key_chan.valid <= 1'b0;
    key_chan.key   <= '0;
    cfg_chan.valid <= 1'b0;
    cfg_chan.data  <= '0;
    quiet      = 1'b0;
    items_sent = 0;
    foreach (hot_keys[i]) hot_keys[i] = $urandom;
    foreach (warm_keys[i]) warm_keys[i] = $urandom;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_capacity(7'd4);
    foreach (opening[i]) send_key(opening[i]);
    wait_drained();

    // zero capacity acts as one, with four entries already in use:
    // table counts as full and the extras keep counting
    write_capacity(7'd0);
    send_key(32'h0000_0007);
    send_key(32'h0000_0007);
    send_key(32'h0000_0000);
    send_key(32'h1234_5678);
    send_key(32'hFFFF_FFFF);

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      write_capacity(phase_caps[p]);
      // no random gaps on either side during some phases
      quiet = (p == 1 || p == 4);
      for (int n = 0; n < PhaseItems; n++) begin
        // sender pauses once mid-phase until everything is back
        if (p == 2 && n == PhaseItems / 2) wait_drained();
        send_key(pick_key());
      end
    end
    quiet = 1'b0;

    wait_drained();
    // latency tail: anything spurious would show up here
    repeat (80) @(posedge clk_i);

    $display("checked %0d results for %0d keys, %0d evictions", checked, items_sent, evictions);
    $display("capacity went 4, 0, 1, 8, 127, 64, 30, 2 with long result stalls and a drain");
    if (mismatches == 0 && outstanding == 0) begin
      $display("space_saving_heavy_hitter_table_unit verification clean");
    end else begin
      $display("space_saving_heavy_hitter_table_unit verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
